@@ sv/b32e_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the character map for the base32 stream encoder
// no dependencies

package b32e_pkg;

    localparam int SYM_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int MAX_SYMS    = 3;
    localparam int NSYM_W      = 2;
    localparam int NPAD_W      = 3;
    localparam int IDX_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] PAD_CHAR    = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_2      = 8'h32;
    localparam logic [SYM_W-1:0]  ALPHA_COUNT = 5'd26;

    // byte position within a 5-byte group
    typedef enum logic [2:0] {
        POS_0 = 3'd0,
        POS_1 = 3'd1,
        POS_2 = 3'd2,
        POS_3 = 3'd3,
        POS_4 = 3'd4
    } pos_t;

    // one request from the front to the back: symbols, then '=' padding
    typedef struct packed {
        logic [MAX_SYMS-1:0][SYM_W-1:0] syms;
        logic [NSYM_W-1:0]              nsym;
        logic [NPAD_W-1:0]              npad;
        logic                           eot;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] v);
        logic [CHAR_W-1:0] ch;
        if (v < ALPHA_COUNT) begin
            ch = CHAR_A + {{(CHAR_W-SYM_W){1'b0}}, v};
        end else begin
            ch = CHAR_2 + {{(CHAR_W-SYM_W){1'b0}}, v - ALPHA_COUNT};
        end
        return ch;
    endfunction

endpackage

@@ sv/base32_stream_encoder.sv @@
`timescale 1ns / 1ps
// base32 stream encoder top level: front end, request queue, back end
// depends on b32e_pkg, b32e_front, b32e_fifo, b32e_back
//
// usage:
//   input channel s_valid/s_ready carries one raw byte per request
//   (s_data_byte) and s_final_byte marking the last byte of a message.
//   output channel m_valid/m_ready carries one character per request
//   (m_out_char, A-Z, 2-7 or '=') with m_end_of_text on the last one.
//   each byte yields one or two characters; a final byte that leaves its
//   group open adds a zero-filled leftover character and '=' padding up
//   to eight per group. the back end emits one character per cycle while
//   the queue holds a request and m_ready is high; a final byte can add
//   up to eight characters for its group.
//   with the queue and output register empty, a byte's first character
//   is written to a queue entry when the byte is accepted and then
//   loaded into the output register that drives m_valid.
//   a four-entry request queue lets bytes keep coming while padding drains.
//   reset clears group position, carry bits, queue and output valid bit.
//   when m_ready is low a valid output register holds; the queue fills and
//   s_ready drops once it is full.

module base32_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_end_of_text
);
    import b32e_pkg::*;

    cmd_t push_cmd, head_cmd;
    logic push, full, pop, empty;

    b32e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_valid),
        .data_byte  (s_data_byte),
        .final_byte (s_final_byte),
        .queue_full (full),
        .byte_ready (s_ready),
        .cmd_push   (push),
        .cmd        (push_cmd)
    );

    b32e_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .head      (head_cmd),
        .empty     (empty)
    );

    b32e_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head_cmd),
        .empty       (empty),
        .pop         (pop),
        .out_valid   (m_valid),
        .out_char    (m_out_char),
        .end_of_text (m_end_of_text),
        .out_ready   (m_ready)
    );

endmodule

@@ sv/b32e_front.sv @@
`timescale 1ns / 1ps
// front end: takes raw bytes, splits them into 5-bit symbols and builds requests
// depends on b32e_pkg

module b32e_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_valid,
    input  logic [7:0]                    data_byte,
    input  logic                          final_byte,
    input  logic                          queue_full,
    output logic                          byte_ready,
    output logic                          cmd_push,
    output b32e_pkg::cmd_t                cmd
);
    import b32e_pkg::*;

    pos_t       pos_reg, pos_next;
    logic [3:0] carry_reg, carry_next;
    logic       take;

    assign byte_ready = !queue_full;
    assign take       = byte_valid && !queue_full;
    assign cmd_push   = take;

    always_comb begin
        pos_next = POS_0;
        case (pos_reg)
            POS_1: begin
                pos_next = POS_2;
            end
            POS_2: begin
                pos_next = POS_3;
            end
            POS_3: begin
                pos_next = POS_4;
            end
            POS_4: begin
                pos_next = POS_0;
            end
            default: begin
                pos_next = POS_1;
            end
        endcase
        if (final_byte) begin
            pos_next = POS_0;
        end
    end

    always_comb begin
        logic [SYM_W-1:0] tail;
        logic [NSYM_W-1:0] nsym;
        logic [NPAD_W-1:0] npad;
        logic [7:0] b;
        b          = data_byte;
        cmd.syms   = '0;
        cmd.eot    = final_byte;
        tail       = '0;
        nsym       = 2'd1;
        npad       = 3'd0;
        carry_next = 4'd0;
        case (pos_reg)
            POS_1: begin
                cmd.syms[0] = {carry_reg[2:0], b[7:6]};
                cmd.syms[1] = b[5:1];
                tail        = {b[0], 4'b0};
                nsym        = 2'd2;
                npad        = 3'd4;
                carry_next  = {3'b0, b[0]};
            end
            POS_2: begin
                cmd.syms[0] = {carry_reg[0], b[7:4]};
                tail        = {b[3:0], 1'b0};
                nsym        = 2'd1;
                npad        = 3'd3;
                carry_next  = b[3:0];
            end
            POS_3: begin
                cmd.syms[0] = {carry_reg[3:0], b[7]};
                cmd.syms[1] = b[6:2];
                tail        = {b[1:0], 3'b0};
                nsym        = 2'd2;
                npad        = 3'd1;
                carry_next  = {2'b0, b[1:0]};
            end
            POS_4: begin
                cmd.syms[0] = {carry_reg[1:0], b[7:5]};
                cmd.syms[1] = b[4:0];
                nsym        = 2'd2;
                npad        = 3'd0;
                carry_next  = 4'd0;
            end
            default: begin
                cmd.syms[0] = b[7:3];
                tail        = {b[2:0], 2'b0};
                nsym        = 2'd1;
                npad        = 3'd6;
                carry_next  = {1'b0, b[2:0]};
            end
        endcase

        // a group that closed on this byte has no tail and no padding
        if (final_byte && pos_reg != POS_4) begin
            cmd.syms[nsym] = tail;
            cmd.nsym       = nsym + 2'd1;
            cmd.npad       = npad;
        end else begin
            cmd.nsym       = nsym;
            cmd.npad       = 3'd0;
        end
        if (final_byte) begin
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_0;
            carry_reg <= 4'd0;
        end else if (take) begin
            pos_reg   <= pos_next;
            carry_reg <= carry_next;
        end
    end

endmodule

@@ sv/b32e_fifo.sv @@
`timescale 1ns / 1ps
// short request queue between the front and back ends
// depends on b32e_pkg

module b32e_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b32e_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output b32e_pkg::cmd_t head,
    output logic           empty
);
    import b32e_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/b32e_back.sv @@
`timescale 1ns / 1ps
// back end: walks each request one character per cycle into the output register
// while out_ready allows it; depends on b32e_pkg

module b32e_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  b32e_pkg::cmd_t head,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    output logic [7:0]     out_char,
    output logic           end_of_text,
    input  logic           out_ready
);
    import b32e_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              eot_reg, eot_next;
    logic [IDX_W-1:0]  total;
    logic              last_char, load;

    assign total     = IDX_W'(head.nsym) + IDX_W'(head.npad);
    assign last_char = (idx_reg == total - 1'b1);
    assign load      = !empty && (!valid_reg || out_ready);
    assign pop       = load && last_char;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        eot_next   = eot_reg;
        if (load) begin
            valid_next = 1'b1;
            eot_next   = head.eot && last_char;
            if (idx_reg < IDX_W'(head.nsym)) begin
                char_next = sym_to_char(head.syms[idx_reg[NSYM_W-1:0]]);
            end else begin
                char_next = PAD_CHAR;
            end
            idx_next = last_char ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        eot_reg  <= eot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign end_of_text = eot_reg;

endmodule
